// ===== rtl/ils_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ils_pkg;

    localparam int CAPACITY_DEF  = 16;
    localparam int WORD_BITS_DEF = 32;

    localparam int FUNC_W   = 2;
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SET    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    // per-cell update select
    localparam int CELL_OP_W = 2;
    localparam logic [CELL_OP_W-1:0] CELL_HOLD    = 2'd0;
    localparam logic [CELL_OP_W-1:0] CELL_LOAD    = 2'd1;
    localparam logic [CELL_OP_W-1:0] CELL_FROM_LO = 2'd2;
    localparam logic [CELL_OP_W-1:0] CELL_FROM_HI = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] word_in;
    } t_request;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   word_out;
        logic [COUNT_W-1:0]  count;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/ils_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ils_cell #(
    parameter int WORD_BITS = ils_pkg::WORD_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic [ils_pkg::CELL_OP_W-1:0]    i_op,
    input  wire logic [WORD_BITS-1:0]             i_word,
    input  wire logic [WORD_BITS-1:0]             i_lo_word,
    input  wire logic [WORD_BITS-1:0]             i_hi_word,
    output logic      [WORD_BITS-1:0]             o_word
);

    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] n_word;

    always_comb begin
        unique case (i_op)
            ils_pkg::CELL_HOLD:    n_word = r_word;
            ils_pkg::CELL_LOAD:    n_word = i_word;
            ils_pkg::CELL_FROM_LO: n_word = i_lo_word;
            ils_pkg::CELL_FROM_HI: n_word = i_hi_word;
            default:               n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

// ===== rtl/indexed_list_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to CAPACITY words with append, insert, set and remove.
// Every entry sits in its own cell; insert and remove move all later entries
// one place at once, so a request is taken in every cycle and busy never
// rises. The result (status, old or removed word, new count) shows on
// o_result for exactly one cycle, marked by o_done, in the cycle after the
// request is accepted; the receiver cannot stall it and must take it then.
// The per-request path is the index compare in each cell plus the
// CAPACITY-way read select for set and remove. Words are stored at
// WORD_BITS bits; the count port shows the low five bits of the count.
module indexed_list_store #(
    parameter int CAPACITY  = ils_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = ils_pkg::WORD_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire ils_pkg::t_request i_req,
    output logic                   o_done,
    output ils_pkg::t_result       o_result
);

    localparam int CW = ($clog2(CAPACITY + 1) > ils_pkg::POS_W) ?
                        $clog2(CAPACITY + 1) : ils_pkg::POS_W;
    localparam int AW = $clog2(CAPACITY);

    logic                         w_accept;
    logic [CW-1:0]                w_pos;
    logic                         w_full;
    logic                         w_ok;
    logic                         w_read;
    logic [ils_pkg::STATUS_W-1:0] w_status;
    logic [63:0]                  w_in64;
    logic [WORD_BITS-1:0]         w_in;
    logic [WORD_BITS-1:0]         w_rd;
    logic [63:0]                  w_rd64;

    logic [WORD_BITS-1:0] w_word [CAPACITY];
    logic [WORD_BITS-1:0] w_lo   [CAPACITY];
    logic [WORD_BITS-1:0] w_hi   [CAPACITY];
    logic [ils_pkg::CELL_OP_W-1:0] w_op [CAPACITY];

    logic [CW-1:0]                r_used;
    logic [CW-1:0]                n_used;
    logic                         r_done;
    logic [ils_pkg::STATUS_W-1:0] r_status;
    logic [ils_pkg::DATA_W-1:0]   r_word_out;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_pos    = CW'(i_req.position);
    assign w_full   = (r_used == CW'(CAPACITY));
    assign w_in64   = 64'(i_req.word_in);
    assign w_in     = w_in64[WORD_BITS-1:0];

    always_comb begin
        w_status = ils_pkg::ST_OK;
        w_read   = 1'b0;
        n_used   = r_used;
        unique case (i_req.func)
            ils_pkg::FUNC_APPEND: begin
                if (w_full) begin
                    w_status = ils_pkg::ST_FULL;
                end else begin
                    n_used = r_used + CW'(1);
                end
            end
            ils_pkg::FUNC_INSERT: begin
                // index check ranks above the full check
                if (w_pos > r_used) begin
                    w_status = ils_pkg::ST_BAD_INDEX;
                end else if (w_full) begin
                    w_status = ils_pkg::ST_FULL;
                end else begin
                    n_used = r_used + CW'(1);
                end
            end
            ils_pkg::FUNC_SET: begin
                if (w_pos >= r_used) begin
                    w_status = ils_pkg::ST_BAD_INDEX;
                end else begin
                    w_read = 1'b1;
                end
            end
            ils_pkg::FUNC_REMOVE: begin
                if (w_pos >= r_used) begin
                    w_status = ils_pkg::ST_BAD_INDEX;
                end else begin
                    w_read = 1'b1;
                    n_used = r_used - CW'(1);
                end
            end
            default: begin
                w_status = ils_pkg::ST_BAD_INDEX;
            end
        endcase
    end

    assign w_ok = (w_status == ils_pkg::ST_OK);

    genvar j;
    generate
        for (j = 0; j < CAPACITY; j++) begin : g_cell
            localparam logic [CW-1:0] IDX = CW'(j);

            if (j == 0) begin : g_lo_edge
                assign w_lo[j] = '0;
            end else begin : g_lo_link
                assign w_lo[j] = w_word[j-1];
            end

            if (j == CAPACITY - 1) begin : g_hi_edge
                assign w_hi[j] = '0;
            end else begin : g_hi_link
                assign w_hi[j] = w_word[j+1];
            end

            always_comb begin
                w_op[j] = ils_pkg::CELL_HOLD;
                if (w_accept && w_ok) begin
                    unique case (i_req.func)
                        ils_pkg::FUNC_APPEND: begin
                            if (IDX == r_used) w_op[j] = ils_pkg::CELL_LOAD;
                        end
                        ils_pkg::FUNC_INSERT: begin
                            if (IDX == w_pos) begin
                                w_op[j] = ils_pkg::CELL_LOAD;
                            end else if (IDX > w_pos) begin
                                w_op[j] = ils_pkg::CELL_FROM_LO;
                            end
                        end
                        ils_pkg::FUNC_SET: begin
                            if (IDX == w_pos) w_op[j] = ils_pkg::CELL_LOAD;
                        end
                        ils_pkg::FUNC_REMOVE: begin
                            if (IDX >= w_pos) w_op[j] = ils_pkg::CELL_FROM_HI;
                        end
                        default: begin
                            w_op[j] = ils_pkg::CELL_HOLD;
                        end
                    endcase
                end
            end

            ils_cell #(
                .WORD_BITS (WORD_BITS)
            ) u_cell (
                .i_clk     (i_clk),
                .i_op      (w_op[j]),
                .i_word    (w_in),
                .i_lo_word (w_lo[j]),
                .i_hi_word (w_hi[j]),
                .o_word    (w_word[j])
            );
        end
    endgenerate

    // only looked at when the index is below the count
    assign w_rd   = w_word[w_pos[AW-1:0]];
    assign w_rd64 = 64'(w_rd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= w_accept;
            if (w_accept) begin
                r_used <= n_used;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status   <= w_status;
            r_word_out <= w_read ? w_rd64[ils_pkg::DATA_W-1:0] : '0;
        end
    end

    assign o_done            = r_done;
    assign o_result.status   = r_status;
    assign o_result.word_out = r_word_out;
    assign o_result.count    = r_used[ils_pkg::COUNT_W-1:0];

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(CAPACITY))
        else $error("list count above capacity");

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && w_accept) |=> o_done)
        else $error("accepted request gave no result strobe");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && w_accept && i_req.func == ils_pkg::FUNC_APPEND && !w_full)
        |=> (r_used == $past(r_used) + CW'(1)))
        else $error("append did not advance the count");

    a_err_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != ils_pkg::ST_OK) |-> (o_result.word_out == '0))
        else $error("error result carries a word");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import ils_pkg::*;

    localparam int LIST_CAP   = CAPACITY_DEF;
    localparam int TAIL_ITEMS = 100;
    localparam int RAND_ITEMS = 650;

    typedef struct {
        t_request req;
        bit       drain_first;
    } t_pending;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    t_request i_req   = '0;
    logic     busy;
    logic     o_done;
    t_result  o_result;

    indexed_list_store uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #10 i_clk = ~i_clk;

    t_pending          pending_reqs[$];
    t_result           expected_results[$];
    logic [DATA_W-1:0] list_words[LIST_CAP];
    int                list_len = 0;
    int                gen_len = 0;
    int                idle_left = 0;
    int                mismatch_count = 0;

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // applies one request to the local copy of the list and returns the result
    function automatic t_result apply_list_op(input t_request req);
        t_result res;
        int      pos;
        int      j;
        res        = '0;
        res.status = ST_OK;
        pos        = req.position;
        case (req.func)
            FUNC_APPEND: begin
                if (list_len >= LIST_CAP) begin
                    res.status = ST_FULL;
                end else begin
                    list_words[list_len] = req.word_in;
                    list_len++;
                end
            end
            FUNC_INSERT: begin
                // index check wins over the full check
                if (pos > list_len) begin
                    res.status = ST_BAD_INDEX;
                end else if (list_len >= LIST_CAP) begin
                    res.status = ST_FULL;
                end else begin
                    for (j = list_len; j > pos; j--)
                        list_words[j] = list_words[j-1];
                    list_words[pos] = req.word_in;
                    list_len++;
                end
            end
            FUNC_SET: begin
                if (pos >= list_len) begin
                    res.status = ST_BAD_INDEX;
                end else begin
                    res.word_out    = list_words[pos];
                    list_words[pos] = req.word_in;
                end
            end
            default: begin
                if (pos >= list_len) begin
                    res.status = ST_BAD_INDEX;
                end else begin
                    res.word_out = list_words[pos];
                    for (j = pos; j + 1 < list_len; j++)
                        list_words[j] = list_words[j+1];
                    list_len--;
                end
            end
        endcase
        res.count = list_len[COUNT_W-1:0];
        return res;
    endfunction

    // list length after a request, used to steer the fill loop and the random positions
    function automatic int len_after(input t_request req, input int len);
        int pos;
        pos = req.position;
        case (req.func)
            FUNC_APPEND: return (len < LIST_CAP) ? len + 1 : len;
            FUNC_INSERT: return (pos <= len && len < LIST_CAP) ? len + 1 : len;
            FUNC_SET:    return len;
            default:     return (pos < len) ? len - 1 : len;
        endcase
    endfunction

    task automatic add_req(input logic [FUNC_W-1:0] func, input int pos,
                           input logic [DATA_W-1:0] word, input bit drain = 1'b0);
        t_pending p;
        p.req.func     = func;
        p.req.position = pos[POS_W-1:0];
        p.req.word_in  = word;
        p.drain_first  = drain;
        gen_len        = len_after(p.req, gen_len);
        pending_reqs.push_back(p);
    endtask

    // driver
    always @(posedge i_clk) begin
        logic     next_start;
        t_request next_req;
        next_start = start;
        next_req   = i_req;
        if (!i_rst_n) begin
            next_start = 1'b0;
        end else if (!start || !busy) begin
            next_start = 1'b0;
            if (idle_left > 0) begin
                idle_left--;
            end else if (pending_reqs.size() != 0) begin
                if (pending_reqs[0].drain_first) begin
                    // hold off until every outstanding request has answered
                    if (!start && expected_results.size() == 0)
                        pending_reqs[0].drain_first = 1'b0;
                end else if (pending_reqs.size() > TAIL_ITEMS &&
                             $urandom_range(0, 5) == 0) begin
                    idle_left = $urandom_range(0, 2);
                end else begin
                    next_start = 1'b1;
                    next_req   = pending_reqs.pop_front().req;
                end
            end
        end
        start <= next_start;
        i_req <= next_req;
    end

    // monitor: predict on acceptance, then check any result of this edge
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (start && !busy)
                expected_results.push_back(apply_list_op(i_req));
            if (o_done === 1'b1) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %h with no request pending", o_result));
                end else begin
                    want = expected_results.pop_front();
                    if (o_result.status !== want.status)
                        report_mismatch($sformatf("status got %0d expected %0d",
                                                  o_result.status, want.status));
                    if (o_result.word_out !== want.word_out)
                        report_mismatch($sformatf("word_out got %h expected %h",
                                                  o_result.word_out, want.word_out));
                    if (o_result.count !== want.count)
                        report_mismatch($sformatf("count got %0d expected %0d",
                                                  o_result.count, want.count));
                end
            end else if (o_done !== 1'b0) begin
                report_mismatch("o_done unknown");
            end
        end
    end

    initial begin
        int          i;
        int          k;
        int          mode;
        int          r;
        int          pos;
        logic [FUNC_W-1:0] func;
        logic [DATA_W-1:0] word;

        // empty and short list corners
        add_req(FUNC_REMOVE, 0, 32'h1111_1111);
        add_req(FUNC_SET, 0, 32'h2222_2222);
        add_req(FUNC_INSERT, 1, 32'h3333_3333);
        add_req(FUNC_INSERT, 0, 32'hFFFF_FFFF);
        add_req(FUNC_APPEND, 0, 32'h0000_0000);
        add_req(FUNC_INSERT, 2, 32'hA5A5_5A5A);
        add_req(FUNC_INSERT, 31, 32'hDEAD_BEEF);
        add_req(FUNC_SET, 2, 32'h1234_5678);
        add_req(FUNC_SET, 3, 32'h8765_4321);
        add_req(FUNC_REMOVE, 31, 32'h0);
        add_req(FUNC_INSERT, 1, 32'h0F0F_0F0F);
        add_req(FUNC_REMOVE, 1, 32'h0);
        // fill up, then full list corners; append ignores the position field
        while (gen_len < LIST_CAP)
            add_req(FUNC_APPEND, 31, $urandom);
        add_req(FUNC_APPEND, 0, 32'hCAFE_F00D);
        add_req(FUNC_INSERT, 17, 32'h5555_5555);
        add_req(FUNC_INSERT, 16, 32'hAAAA_AAAA);
        add_req(FUNC_SET, 15, 32'h7777_7777);
        add_req(FUNC_REMOVE, 0, 32'h0, 1'b1);
        add_req(FUNC_REMOVE, 14, 32'h0);

        mode = 0;
        for (i = 0; i < RAND_ITEMS; i++) begin
            if (i % 50 == 0)
                mode = $urandom_range(0, 2);
            r = $urandom_range(0, 99);
            case (mode)
                0: func = (r < 35) ? FUNC_APPEND : (r < 70) ? FUNC_INSERT :
                          (r < 85) ? FUNC_SET : FUNC_REMOVE;
                1: func = (r < 10) ? FUNC_APPEND : (r < 20) ? FUNC_INSERT :
                          (r < 40) ? FUNC_SET : FUNC_REMOVE;
                default: func = r[1:0];
            endcase
            if ($urandom_range(0, 99) < 15)
                pos = $urandom_range(0, 31);
            else if (func == FUNC_INSERT || func == FUNC_APPEND)
                pos = $urandom_range(0, gen_len);
            else
                pos = (gen_len > 0) ? $urandom_range(0, gen_len - 1) : 0;
            r = $urandom_range(0, 19);
            word = (r == 0) ? '0 : (r == 1) ? '1 : $urandom;
            add_req(func, pos, word, (i % 160 == 80));
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk); while (pending_reqs.size() != 0 || start);
        for (k = 0; k < 50 && expected_results.size() != 0; k++)
            @(negedge i_clk);
        repeat (5) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ils_pkg.sv
rtl/ils_cell.sv
rtl/indexed_list_store.sv
test/tb.sv
